@@ src/aoafd_pkg.sv @@
// aoafd_pkg: shared types and constants of the header/length/xor deframer
// no dependencies; used by aoafd_parse, aoafd_out_reg, the top level and the bench

`default_nettype none

package aoafd_pkg;

    // frame geometry
    localparam int FRAME_BYTES = 37;
    localparam int IDX_W       = 6;

    localparam logic [15:0]      FRAME_LEN16    = 16'(FRAME_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX       = IDX_W'(FRAME_BYTES - 1);
    localparam logic [IDX_W-1:0] LEN_HI_IDX     = IDX_W'(4);
    localparam logic [IDX_W-1:0] LEN_LO_IDX     = IDX_W'(5);
    localparam logic [IDX_W-1:0] BODY_FIRST_IDX = IDX_W'(6);
    localparam logic [IDX_W-1:0] DIST_FIRST     = IDX_W'(20);
    localparam logic [IDX_W-1:0] DIST_LAST      = IDX_W'(23);
    localparam logic [IDX_W-1:0] AZ_FIRST       = IDX_W'(24);
    localparam logic [IDX_W-1:0] AZ_LAST        = IDX_W'(25);
    localparam logic [IDX_W-1:0] EL_FIRST       = IDX_W'(26);
    localparam logic [IDX_W-1:0] EL_LAST        = IDX_W'(27);

    localparam logic [7:0] HDR_BYTE    = 8'hFF;
    localparam logic [1:0] HDR_RUN_END = 2'd3;

    // parser phase, one-hot
    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_LEN  = 3'b010,
        PH_BODY = 3'b100
    } t_phase;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_LEN = 2'd1,
        ST_BAD_SUM = 2'd2
    } t_status;

    // one result item
    typedef struct packed {
        t_status             status;
        logic [15:0]         length_field;
        logic [31:0]         distance_cm;
        logic signed [15:0]  azimuth_deg;
        logic signed [15:0]  elevation_deg;
    } t_result;

endpackage

`default_nettype wire

@@ src/aoafd_in_reg.sv @@
// aoafd_in_reg: input byte register with valid/stall handshake
// depends on nothing beyond the port list

`default_nettype none

module aoafd_in_reg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_in_stall,
    input  wire logic       i_out_free,
    output logic            o_proc,
    output logic [7:0]      o_byte
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       accept;

    // held byte waits only while the result side is full and stalled
    assign o_in_stall = r_valid && !i_out_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_proc     = r_valid && i_out_free;
    assign o_byte     = r_byte;

    // valid next state
    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_proc) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload capture on transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_rx_byte;
        end
    end

endmodule

`default_nettype wire

@@ src/aoafd_parse.sv @@
// aoafd_parse: header hunt, length check, body collection and checksum
// depends on aoafd_pkg

`default_nettype none

module aoafd_parse (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_proc,
    input  wire logic [7:0]         i_byte,
    output logic                    o_res_valid,
    output aoafd_pkg::t_result      o_res
);

    aoafd_pkg::t_phase                r_phase, n_phase;
    logic [1:0]                       r_run, n_run;
    logic [aoafd_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic [7:0]                       r_xor, n_xor;
    logic [7:0]                       r_lenhi, n_lenhi;
    logic [31:0]                      r_dist, n_dist;
    logic [15:0]                      r_az, n_az;
    logic [15:0]                      r_el, n_el;
    logic                             restart;
    logic [15:0]                      len_rx;

    assign len_rx = {r_lenhi, i_byte};

    // per-byte state update and result build
    always_comb begin
        n_phase     = r_phase;
        n_run       = r_run;
        n_idx       = r_idx;
        n_xor       = r_xor;
        n_lenhi     = r_lenhi;
        n_dist      = r_dist;
        n_az        = r_az;
        n_el        = r_el;
        restart     = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_proc) begin
            case (r_phase)
                aoafd_pkg::PH_LEN: begin
                    n_xor = r_xor ^ i_byte;
                    if (r_idx == aoafd_pkg::LEN_HI_IDX) begin
                        n_lenhi = i_byte;
                        n_idx   = aoafd_pkg::LEN_LO_IDX;
                    end else if (len_rx != aoafd_pkg::FRAME_LEN16) begin
                        o_res_valid        = 1'b1;
                        o_res.status       = aoafd_pkg::ST_BAD_LEN;
                        o_res.length_field = len_rx;
                        restart            = 1'b1;
                    end else begin
                        n_idx   = aoafd_pkg::BODY_FIRST_IDX;
                        n_phase = aoafd_pkg::PH_BODY;
                    end
                end
                aoafd_pkg::PH_BODY: begin
                    if (r_idx >= aoafd_pkg::LAST_IDX) begin
                        o_res_valid        = 1'b1;
                        o_res.length_field = aoafd_pkg::FRAME_LEN16;
                        if (r_xor == i_byte) begin
                            o_res.status        = aoafd_pkg::ST_OK;
                            o_res.distance_cm   = r_dist;
                            o_res.azimuth_deg   = $signed(r_az);
                            o_res.elevation_deg = $signed(r_el);
                        end else begin
                            o_res.status = aoafd_pkg::ST_BAD_SUM;
                        end
                        restart = 1'b1;
                    end else begin
                        n_xor = r_xor ^ i_byte;
                        if (r_idx inside {[aoafd_pkg::DIST_FIRST:aoafd_pkg::DIST_LAST]}) begin
                            n_dist = {r_dist[23:0], i_byte};
                        end else if (r_idx inside {[aoafd_pkg::AZ_FIRST:aoafd_pkg::AZ_LAST]}) begin
                            n_az = {r_az[7:0], i_byte};
                        end else if (r_idx inside {[aoafd_pkg::EL_FIRST:aoafd_pkg::EL_LAST]}) begin
                            n_el = {r_el[7:0], i_byte};
                        end
                        n_idx = r_idx + 1'b1;
                    end
                end
                default: begin
                    // hunting, also any stray phase code
                    n_phase = aoafd_pkg::PH_HUNT;
                    if (i_byte == aoafd_pkg::HDR_BYTE) begin
                        if (r_run == aoafd_pkg::HDR_RUN_END) begin
                            n_run   = '0;
                            n_xor   = '0;
                            n_idx   = aoafd_pkg::LEN_HI_IDX;
                            n_dist  = '0;
                            n_az    = '0;
                            n_el    = '0;
                            n_phase = aoafd_pkg::PH_LEN;
                        end else begin
                            n_run = r_run + 1'b1;
                        end
                    end else begin
                        n_run = '0;
                    end
                end
            endcase
            // back to hunting after any result
            if (restart) begin
                n_phase = aoafd_pkg::PH_HUNT;
                n_run   = '0;
                n_idx   = '0;
                n_xor   = '0;
                n_lenhi = '0;
                n_dist  = '0;
                n_az    = '0;
                n_el    = '0;
            end
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= aoafd_pkg::PH_HUNT;
            r_run   <= '0;
            r_idx   <= '0;
            r_xor   <= '0;
            r_lenhi <= '0;
            r_dist  <= '0;
            r_az    <= '0;
            r_el    <= '0;
        end else begin
            r_phase <= n_phase;
            r_run   <= n_run;
            r_idx   <= n_idx;
            r_xor   <= n_xor;
            r_lenhi <= n_lenhi;
            r_dist  <= n_dist;
            r_az    <= n_az;
            r_el    <= n_el;
        end
    end

    // any result sends the parser back to hunting
    a_restart_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_phase == aoafd_pkg::PH_HUNT && r_run == 2'd0))
        else $error("parser not hunting after a result");

    // length phase only ever sits on the two length bytes
    a_len_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == aoafd_pkg::PH_LEN) |->
        (r_idx == aoafd_pkg::LEN_HI_IDX || r_idx == aoafd_pkg::LEN_LO_IDX))
        else $error("length phase at a bad byte index");

    // body index stays between the first body byte and the checksum byte
    a_body_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == aoafd_pkg::PH_BODY) |->
        (r_idx >= aoafd_pkg::BODY_FIRST_IDX && r_idx <= aoafd_pkg::LAST_IDX))
        else $error("body byte index out of frame");

    // a good frame always reports the fixed length
    a_ok_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == aoafd_pkg::ST_OK) |->
        (o_res.length_field == aoafd_pkg::FRAME_LEN16 && r_phase == aoafd_pkg::PH_BODY))
        else $error("good frame result with wrong length or phase");

endmodule

`default_nettype wire

@@ src/aoafd_out_reg.sv @@
// aoafd_out_reg: result register driving the output ports
// depends on aoafd_pkg

`default_nettype none

module aoafd_out_reg (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire aoafd_pkg::t_result   i_res,
    input  wire logic                 i_out_stall,
    output logic                      o_out_valid,
    output logic                      o_free,
    output aoafd_pkg::t_result        o_res
);

    logic               r_valid;
    logic               n_valid;
    aoafd_pkg::t_result r_res;

    // free when empty or being drained this cycle
    assign o_free      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    // valid next state
    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

@@ src/aoa_frame_deframer.sv @@
// aoa_frame_deframer: top level of the header/length/xor-checksum deframer
// depends on aoafd_pkg, aoafd_in_reg, aoafd_parse, aoafd_out_reg

// Takes one byte per cycle, every cycle, for as long as the result side keeps up.
// A byte passes an input register, then the parser logic between the registers, which
// loads the result register when the byte is the one that ends its frame (the checksum
// byte, or the second length byte on a bad length).
// Throughput is one byte per cycle while the result side keeps up, set by the single
// pass through the parser between the two registers. While the result register is
// full and stalled, the input register holds its byte and o_in_stall rises
// combinationally from i_out_stall. Statuses: frame ok, bad length field, checksum
// mismatch; on an error the data fields read zero. No clearing pass after reset.

`default_nettype none

module aoa_frame_deframer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [7:0]    i_rx_byte,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [1:0]         o_status,
    output logic [15:0]        o_length_field,
    output logic [31:0]        o_distance_cm,
    output logic signed [15:0] o_azimuth_deg,
    output logic signed [15:0] o_elevation_deg
);

    logic               out_free;
    logic               proc;
    logic [7:0]         byte_q;
    logic               res_valid;
    aoafd_pkg::t_result res;
    aoafd_pkg::t_result res_q;

    // input byte register
    aoafd_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_rx_byte  (i_rx_byte),
        .o_in_stall (o_in_stall),
        .i_out_free (out_free),
        .o_proc     (proc),
        .o_byte     (byte_q)
    );

    // frame parser
    aoafd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_proc      (proc),
        .i_byte      (byte_q),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register
    aoafd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (res_valid),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_free      (out_free),
        .o_res       (res_q)
    );

    // unpack result fields
    assign o_status        = res_q.status;
    assign o_length_field  = res_q.length_field;
    assign o_distance_cm   = res_q.distance_cm;
    assign o_azimuth_deg   = res_q.azimuth_deg;
    assign o_elevation_deg = res_q.elevation_deg;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// tb: self-checking bench for aoa_frame_deframer, byte transfers in, frame reports out
// depends on aoafd_pkg and the deframer sources under src

module tb;

    typedef enum logic [1:0] {HUNT_HDR, GET_LEN, GET_BODY} t_rx_phase;
    typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_BEAT} t_stall_mode;

    // recipe for one frame on the wire
    typedef struct {
        int                 lead;      // ff bytes of a broken header run ahead of the real one
        logic [15:0]        len;
        logic [31:0]        range_cm;
        logic [15:0]        az;
        logic [15:0]        el;
        bit                 rnd_fill;
        bit                 bad_sum;
        bit                 typed;
        aoafd_pkg::t_result report;
    } t_frame_plan;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [7:0]         i_rx_byte   = 8'h00;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [1:0]         o_status;
    logic [15:0]        o_length_field;
    logic [31:0]        o_distance_cm;
    logic signed [15:0] o_azimuth_deg;
    logic signed [15:0] o_elevation_deg;

    // deframer state as the bench sees it
    t_rx_phase   rx_phase;
    logic [2:0]  hdr_count;
    logic [5:0]  frame_idx;
    logic [7:0]  run_xor;
    logic [7:0]  len_hi_byte;
    logic [31:0] dist_acc;
    logic [15:0] az_acc;
    logic [15:0] el_acc;

    aoafd_pkg::t_result frame_reports[$];
    t_frame_plan        plan_rows[$];
    logic [7:0]         frame_buf[$];
    aoafd_pkg::t_result typed_report;
    bit          use_typed   = 1'b0;
    int          err_count   = 0;
    int          bytes_sent  = 0;
    int          burst_left  = 0;
    t_stall_mode stall_mode  = STALL_NONE;
    int          stall_span  = 0;
    int          stall_tick  = 0;

    aoa_frame_deframer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_length_field  (o_length_field),
        .o_distance_cm   (o_distance_cm),
        .o_azimuth_deg   (o_azimuth_deg),
        .o_elevation_deg (o_elevation_deg)
    );

    always #1 i_clk = ~i_clk;

    // back to header hunting with everything cleared
    task automatic rearm_hunt();
        rx_phase    = HUNT_HDR;
        hdr_count   = 3'd0;
        frame_idx   = 6'd0;
        run_xor     = 8'h00;
        len_hi_byte = 8'h00;
        dist_acc    = 32'd0;
        az_acc      = 16'd0;
        el_acc      = 16'd0;
    endtask

    // one byte through the deframer, at most one report out
    task automatic deframe_byte(input logic [7:0] b, output bit got,
                                output aoafd_pkg::t_result r);
        logic [15:0] len;
        begin
            got = 1'b0;
            r   = '0;
            case (rx_phase)
                GET_LEN: begin
                    run_xor ^= b;
                    if (frame_idx == 6'd4) begin
                        len_hi_byte = b;
                        frame_idx   = 6'd5;
                    end else begin
                        len = {len_hi_byte, b};
                        if (len != aoafd_pkg::FRAME_LEN16) begin
                            got            = 1'b1;
                            r.status       = aoafd_pkg::ST_BAD_LEN;
                            r.length_field = len;
                            rearm_hunt();
                        end else begin
                            frame_idx = 6'd6;
                            rx_phase  = GET_BODY;
                        end
                    end
                end
                GET_BODY: begin
                    if (frame_idx >= 6'(aoafd_pkg::FRAME_BYTES - 1)) begin
                        // checksum byte closes the frame
                        got            = 1'b1;
                        r.length_field = aoafd_pkg::FRAME_LEN16;
                        if (run_xor == b) begin
                            r.status        = aoafd_pkg::ST_OK;
                            r.distance_cm   = dist_acc;
                            r.azimuth_deg   = az_acc;
                            r.elevation_deg = el_acc;
                        end else begin
                            r.status = aoafd_pkg::ST_BAD_SUM;
                        end
                        rearm_hunt();
                    end else begin
                        run_xor ^= b;
                        if (frame_idx >= 6'd20 && frame_idx <= 6'd23)
                            dist_acc = {dist_acc[23:0], b};
                        else if (frame_idx == 6'd24 || frame_idx == 6'd25)
                            az_acc = {az_acc[7:0], b};
                        else if (frame_idx == 6'd26 || frame_idx == 6'd27)
                            el_acc = {el_acc[7:0], b};
                        frame_idx = frame_idx + 6'd1;
                    end
                end
                default: begin
                    rx_phase = HUNT_HDR;
                    if (b == aoafd_pkg::HDR_BYTE) begin
                        hdr_count = hdr_count + 3'd1;
                        if (hdr_count >= 3'd4) begin
                            // header complete, length bytes follow
                            hdr_count = 3'd0;
                            run_xor   = 8'h00;
                            frame_idx = 6'd4;
                            dist_acc  = 32'd0;
                            az_acc    = 16'd0;
                            el_acc    = 16'd0;
                            rx_phase  = GET_LEN;
                        end
                    end else begin
                        hdr_count = 3'd0;
                    end
                end
            endcase
        end
    endtask

    // drive one byte, bursts with random gaps, returns at the edge of its transfer
    task automatic send_byte(input logic [7:0] b);
        int                 gap;
        bit                 got;
        aoafd_pkg::t_result r;
        begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    i_rx_byte  <= 8'($urandom);
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 48);
            end
            i_in_valid <= 1'b1;
            i_rx_byte  <= b;
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
            burst_left--;
            bytes_sent++;
            deframe_byte(b, got, r);
            if (got) begin
                if (use_typed) begin
                    frame_reports.push_back(typed_report);
                    use_typed = 1'b0;
                end else begin
                    frame_reports.push_back(r);
                end
            end
        end
    endtask

    // hold the sender until every outstanding report has come back
    task automatic drain_reports();
        i_in_valid <= 1'b0;
        while (frame_reports.size() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    function automatic t_frame_plan mk_plan(int lead, logic [15:0] len, logic [31:0] range_cm,
                                            logic [15:0] az, logic [15:0] el, bit rnd_fill,
                                            bit bad_sum, bit typed,
                                            aoafd_pkg::t_result report);
        t_frame_plan p;
        p.lead     = lead;
        p.len      = len;
        p.range_cm = range_cm;
        p.az       = az;
        p.el       = el;
        p.rnd_fill = rnd_fill;
        p.bad_sum  = bad_sum;
        p.typed    = typed;
        p.report   = report;
        return p;
    endfunction

    // lay out a frame in frame_buf, stopping after the length on a bad length
    task automatic build_frame(input t_frame_plan p);
        logic [7:0] b;
        logic [7:0] sum;
        begin
            frame_buf.delete();
            sum = 8'h00;
            for (int k = 0; k < p.lead; k++) frame_buf.push_back(aoafd_pkg::HDR_BYTE);
            if (p.lead > 0) frame_buf.push_back(8'($urandom_range(0, 254)));
            for (int k = 0; k < aoafd_pkg::FRAME_BYTES - 1; k++) begin
                if (k < 4)
                    b = aoafd_pkg::HDR_BYTE;
                else if (k == 4)
                    b = p.len[15:8];
                else if (k == 5)
                    b = p.len[7:0];
                else if (k >= 20 && k <= 23)
                    b = p.range_cm[8*(23-k) +: 8];
                else if (k == 24 || k == 25)
                    b = p.az[8*(25-k) +: 8];
                else if (k == 26 || k == 27)
                    b = p.el[8*(27-k) +: 8];
                else
                    b = p.rnd_fill ? 8'($urandom) : 8'h00;
                frame_buf.push_back(b);
                sum ^= b;
                if (k == 5 && p.len != aoafd_pkg::FRAME_LEN16) break;
            end
            if (p.len == aoafd_pkg::FRAME_LEN16)
                frame_buf.push_back(p.bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum);
        end
    endtask

    task automatic send_buf(input int keep);
        for (int k = 0; k < keep && k < frame_buf.size(); k++) send_byte(frame_buf[k]);
    endtask

    // mostly clean frames, some with bad sums, bad lengths, noise or cut short
    task automatic random_frame();
        t_frame_plan p;
        int          pick;
        int          keep;
        int          n;
        begin
            pick = $urandom_range(0, 99);
            keep = 64;
            p = mk_plan(($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0,
                        aoafd_pkg::FRAME_LEN16, $urandom, 16'($urandom), 16'($urandom),
                        1'b1, 1'b0, 1'b0, '0);
            if (pick < 6) begin
                p.range_cm = pick[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
                p.az       = pick[1] ? 16'h8000 : 16'h7FFF;
                p.el       = pick[2] ? 16'h8000 : 16'h7FFF;
            end else if (pick >= 65 && pick < 75) begin
                p.bad_sum = 1'b1;
            end else if (pick >= 75 && pick < 85) begin
                case ($urandom_range(0, 3))
                    0:       p.len = {8'h00, 8'($urandom)};
                    1:       p.len = {8'hFF, 8'($urandom)};
                    2:       p.len = $urandom_range(0, 1) ? aoafd_pkg::FRAME_LEN16 + 16'd1
                                                          : aoafd_pkg::FRAME_LEN16 - 16'd1;
                    default: p.len = 16'($urandom);
                endcase
            end else if (pick >= 93) begin
                keep = $urandom_range(6, aoafd_pkg::FRAME_BYTES - 1);
            end
            if (pick >= 85 && pick < 93) begin
                // line noise, rich in ff
                frame_buf.delete();
                n = $urandom_range(1, 12);
                repeat (n)
                    frame_buf.push_back(($urandom_range(0, 2) == 0) ? aoafd_pkg::HDR_BYTE
                                                                    : 8'($urandom));
            end else begin
                build_frame(p);
            end
            send_buf(keep);
        end
    endtask

    // report checks
    task automatic cmp_field(input string tag, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, tag, want, got);
            err_count++;
        end
    endtask

    task automatic check_report();
        aoafd_pkg::t_result want;
        begin
            if (frame_reports.size() == 0) begin
                $display("%0t: report with none expected, actual status %0d length %h",
                         $time, o_status, o_length_field);
                err_count++;
            end else begin
                want = frame_reports.pop_front();
                cmp_field("status", want.status, o_status);
                cmp_field("length_field", want.length_field, o_length_field);
                cmp_field("distance_cm", want.distance_cm, o_distance_cm);
                cmp_field("azimuth_deg", want.azimuth_deg, o_azimuth_deg);
                cmp_field("elevation_deg", want.elevation_deg, o_elevation_deg);
            end
        end
    endtask

    // receiver: take reports, stall in modes that are picked anew at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) check_report();
            if (stall_span == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_span = $urandom_range(16, 160);
            end
            stall_span--;
            stall_tick++;
            case (stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_HALF:  i_out_stall <= ($urandom_range(0, 1) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                default:     i_out_stall <= ((stall_tick % 5) < 2);
            endcase
        end
    end

    // stimulus and end of run
    initial begin
        int  rnd_start;
        int  spin;
        bit  paused;
        rearm_hunt();
        paused = 1'b0;
        spin   = 0;

        // directed rows: extremes, each status, long ff runs, broken header runs
        plan_rows.push_back(mk_plan(0, aoafd_pkg::FRAME_LEN16, 32'h0, 16'h0, 16'h0, 0, 0, 1,
                                    aoafd_pkg::t_result'{aoafd_pkg::ST_OK, 16'd37, 32'h0,
                                                         16'sh0, 16'sh0}));
        plan_rows.push_back(mk_plan(0, aoafd_pkg::FRAME_LEN16, 32'hFFFF_FFFF, 16'h7FFF,
                                    16'h8000, 0, 0, 1,
                                    aoafd_pkg::t_result'{aoafd_pkg::ST_OK, 16'd37,
                                                         32'hFFFF_FFFF, 16'sh7FFF,
                                                         16'sh8000}));
        plan_rows.push_back(mk_plan(0, aoafd_pkg::FRAME_LEN16, 32'h0000_0001, 16'hFFFF,
                                    16'h7FFF, 1, 0, 1,
                                    aoafd_pkg::t_result'{aoafd_pkg::ST_OK, 16'd37,
                                                         32'h0000_0001, 16'shFFFF,
                                                         16'sh7FFF}));
        plan_rows.push_back(mk_plan(0, aoafd_pkg::FRAME_LEN16, 32'h8000_0000, 16'h8000,
                                    16'hFFFF, 1, 0, 1,
                                    aoafd_pkg::t_result'{aoafd_pkg::ST_OK, 16'd37,
                                                         32'h8000_0000, 16'sh8000,
                                                         16'shFFFF}));
        plan_rows.push_back(mk_plan(0, 16'h0000, 32'h0, 16'h0, 16'h0, 0, 0, 1,
                                    aoafd_pkg::t_result'{aoafd_pkg::ST_BAD_LEN, 16'h0000,
                                                         32'h0, 16'sh0, 16'sh0}));
        plan_rows.push_back(mk_plan(0, 16'hFFFF, 32'h0, 16'h0, 16'h0, 0, 0, 1,
                                    aoafd_pkg::t_result'{aoafd_pkg::ST_BAD_LEN, 16'hFFFF,
                                                         32'h0, 16'sh0, 16'sh0}));
        plan_rows.push_back(mk_plan(0, 16'hFF25, 32'h0, 16'h0, 16'h0, 0, 0, 1,
                                    aoafd_pkg::t_result'{aoafd_pkg::ST_BAD_LEN, 16'hFF25,
                                                         32'h0, 16'sh0, 16'sh0}));
        plan_rows.push_back(mk_plan(0, 16'd36, 32'h0, 16'h0, 16'h0, 0, 0, 1,
                                    aoafd_pkg::t_result'{aoafd_pkg::ST_BAD_LEN, 16'd36,
                                                         32'h0, 16'sh0, 16'sh0}));
        plan_rows.push_back(mk_plan(0, 16'd38, 32'h0, 16'h0, 16'h0, 0, 0, 1,
                                    aoafd_pkg::t_result'{aoafd_pkg::ST_BAD_LEN, 16'd38,
                                                         32'h0, 16'sh0, 16'sh0}));
        plan_rows.push_back(mk_plan(2, 16'h0125, 32'h0, 16'h0, 16'h0, 0, 0, 1,
                                    aoafd_pkg::t_result'{aoafd_pkg::ST_BAD_LEN, 16'h0125,
                                                         32'h0, 16'sh0, 16'sh0}));
        plan_rows.push_back(mk_plan(0, aoafd_pkg::FRAME_LEN16, 32'h1234_5678, 16'h1234,
                                    16'hEDCC, 1, 1, 1,
                                    aoafd_pkg::t_result'{aoafd_pkg::ST_BAD_SUM, 16'd37,
                                                         32'h0, 16'sh0, 16'sh0}));
        plan_rows.push_back(mk_plan(3, aoafd_pkg::FRAME_LEN16, 32'h0BAD_F00D, 16'h5A5A,
                                    16'hA5A5, 1, 0, 0, '0));
        plan_rows.push_back(mk_plan(1, aoafd_pkg::FRAME_LEN16, 32'hC0FF_EE00, 16'h0101,
                                    16'hFEFE, 1, 1, 0, '0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan_rows[n]) begin
            use_typed    = plan_rows[n].typed;
            typed_report = plan_rows[n].report;
            build_frame(plan_rows[n]);
            send_buf(frame_buf.size());
        end
        use_typed = 1'b0;
        drain_reports();

        // random traffic, with one full drain part-way through
        rnd_start = bytes_sent;
        while (bytes_sent - rnd_start < 1700) begin
            random_frame();
            if (!paused && bytes_sent - rnd_start >= 850) begin
                drain_reports();
                paused = 1'b1;
            end
        end
        i_in_valid <= 1'b0;

        while (frame_reports.size() != 0 && spin < 20000) begin
            @(posedge i_clk);
            spin++;
        end
        if (frame_reports.size() != 0) begin
            $display("%0t: %0d expected reports never arrived", $time, frame_reports.size());
            err_count++;
        end
        repeat (8) @(posedge i_clk);

        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ sim.f @@
src/aoafd_pkg.sv
src/aoafd_in_reg.sv
src/aoafd_parse.sv
src/aoafd_out_reg.sv
src/aoa_frame_deframer.sv
verif/tb.sv
